@@ hw/rtl/acpu_pkg.sv @@
// ----------------------------------------------------------------------------
// acpu_pkg
// shared types and constants for the 16-bit accumulator processor
// ----------------------------------------------------------------------------
package acpu_pkg;

  localparam int unsigned MemWordsDefault = 4096;
  localparam int unsigned WordW = 16;
  localparam int unsigned AddrW = 12;
  localparam int unsigned OpW   = 4;

  typedef enum logic [OpW-1:0] {
    OpHalt  = 4'h0,
    OpLdM   = 4'h1,
    OpLdMq  = 4'h2,
    OpLdMqM = 4'h3,
    OpSt    = 4'h4,
    OpStAdr = 4'h5,
    OpAdd   = 4'h6,
    OpSub   = 4'h7,
    OpMul   = 4'h8,
    OpDiv   = 4'h9,
    OpJmp   = 4'hA,
    OpJz    = 4'hB,
    OpJnz   = 4'hC,
    OpJge   = 4'hD,
    OpIn    = 4'hE,
    OpOut   = 4'hF
  } op_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StFetch,
    StDecode,
    StOperand,
    StExec,
    StDiv,
    StDivFix,
    StWrite,
    StOut
  } state_e;

endpackage

@@ hw/rtl/accumulator_cpu_16bit.sv @@
// ----------------------------------------------------------------------------
// accumulator_cpu_16bit
// accumulator processor with one word memory, one request per load or step
// ----------------------------------------------------------------------------
// After reset the block sweeps the memory to zero, one word a cycle, and
// takes no request meanwhile. A load request goes straight to the result; a
// step runs fetch read, decode with operand read, operand capture, execute,
// write-back and result in turn, since both reads share the single memory
// port; a divide adds its one-bit-per-cycle restoring divider. A step while
// halted goes straight to the result. The result sits in an output register
// and the next request is taken from the cycle after it has been delivered.
module accumulator_cpu_16bit #(
  parameter int unsigned MEM_WORDS = acpu_pkg::MemWordsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [acpu_pkg::AddrW-1:0] load_address_i,
  input  logic [acpu_pkg::WordW-1:0] load_data_i,
  input  logic signed [acpu_pkg::WordW-1:0] io_in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [acpu_pkg::OpW-1:0]  opcode_done_o,
  output logic [acpu_pkg::AddrW-1:0] next_pc_o,
  output logic signed [acpu_pkg::WordW-1:0] acc_value_o,
  output logic signed [acpu_pkg::WordW-1:0] mq_value_o,
  output logic                      halted_o,
  output logic                      div_error_o,
  output logic                      in_taken_o,
  output logic                      out_valid_flag_o,
  output logic signed [acpu_pkg::WordW-1:0] out_value_o
);
  import acpu_pkg::*;

  localparam int unsigned MemAw = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned CntW  = $clog2(WordW + 1);

  logic [WordW-1:0] mem_q [MEM_WORDS];
  logic [WordW-1:0] rdata_q;
  logic             mem_we;
  logic [MemAw-1:0] mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata;

  state_e state_q, state_d;
  logic [MemAw-1:0] clr_q, clr_d;
  logic [AddrW-1:0] pc_q, pc_d;
  logic [WordW-1:0] ac_q, ac_d, mq_q, mq_d;
  logic             halt_q, halt_d, err_q, err_d;
  logic [WordW-1:0] ir_q, ir_d, opnd_q, opnd_d;
  logic             ir_ok_q, ir_ok_d, x_ok_q, x_ok_d;
  logic [WordW-1:0] io_q, io_d;
  logic [OpW-1:0]   ro_op_q, ro_op_d;
  logic             ro_in_q, ro_in_d, ro_out_q, ro_out_d;
  logic [WordW-1:0] ro_val_q, ro_val_d;
  logic             ovalid_q, ovalid_d;
  logic signed [2*WordW-1:0] prod;
  logic [WordW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic             nega_q, nega_d, negb_q, negb_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW:0]   trial;
  logic [WordW-1:0] rem_sh;
  logic [AddrW-1:0] xaddr;
  logic             req;

  assign xaddr = ir_q[AddrW-1:0];
  assign req   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle) && !ovalid_q;
  assign prod  = $signed(mq_q) * $signed(opnd_q);
  assign rem_sh = {rem_q[WordW-2:0], quo_q[WordW-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:   if (32'(clr_q) == MEM_WORDS - 1) state_d = StIdle;
      StIdle:    if (req) state_d = (in_valid_i && !func_i) ? StOut :
                                    (halt_q ? StOut : StFetch);
      StFetch:   state_d = StDecode;
      StDecode:  state_d = StOperand;
      StOperand: state_d = StExec;
      StExec:    state_d = (ir_q[WordW-1 -: OpW] == OpDiv && opnd_q != '0) ? StDiv : StWrite;
      StDiv:     if (cnt_q == CntW'(WordW - 1)) state_d = StDivFix;
      StDivFix:  state_d = StWrite;
      StWrite:   state_d = StOut;
      StOut:     state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    clr_d = clr_q; pc_d = pc_q; ac_d = ac_q; mq_d = mq_q;
    halt_d = halt_q; err_d = err_q; ir_d = ir_q; opnd_d = opnd_q;
    ir_ok_d = ir_ok_q; x_ok_d = x_ok_q;
    io_d = io_q;
    ro_op_d = ro_op_q; ro_in_d = ro_in_q; ro_out_d = ro_out_q; ro_val_d = ro_val_q;
    ovalid_d = ovalid_q && !out_ready_i;
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; nega_d = nega_q; negb_d = negb_q;
    cnt_d = cnt_q;
    mem_we = 1'b0; mem_waddr = clr_q; mem_wdata = '0;
    mem_raddr = pc_q[MemAw-1:0];
    unique case (state_q)
      StClear: begin
        mem_we = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      StIdle: begin
        if (req) begin
          io_d = io_in_i;
          ro_op_d = OpHalt; ro_in_d = 1'b0; ro_out_d = 1'b0; ro_val_d = '0;
          if (!func_i && 32'(load_address_i) < MEM_WORDS) begin
            mem_we = 1'b1; mem_waddr = load_address_i[MemAw-1:0];
            mem_wdata = load_data_i;
          end
        end
      end
      StFetch: begin
        ir_ok_d = 32'(pc_q) < MEM_WORDS;
      end
      StDecode: begin
        ir_d = ir_ok_q ? rdata_q : '0;
        mem_raddr = rdata_q[MemAw-1:0];
        x_ok_d = 32'(rdata_q[AddrW-1:0]) < MEM_WORDS;
        pc_d = pc_q + 1'b1;
      end
      StOperand: begin
        opnd_d = x_ok_q ? rdata_q : '0;
      end
      StExec: begin
        ro_op_d = ir_q[WordW-1 -: OpW];
        unique case (op_e'(ir_q[WordW-1 -: OpW]))
          OpHalt:  halt_d = 1'b1;
          OpLdM:   ac_d = opnd_q;
          OpLdMq:  ac_d = mq_q;
          OpLdMqM: mq_d = opnd_q;
          OpSt: if (x_ok_q) begin
            mem_we = 1'b1; mem_waddr = xaddr[MemAw-1:0]; mem_wdata = ac_q;
          end
          OpStAdr: if (x_ok_q) begin
            mem_we = 1'b1; mem_waddr = xaddr[MemAw-1:0];
            mem_wdata = {opnd_q[WordW-1 -: OpW], ac_q[AddrW-1:0]};
          end
          OpAdd:   ac_d = ac_q + opnd_q;
          OpSub:   ac_d = ac_q - opnd_q;
          OpMul: begin
            ac_d = prod[2*WordW-1:WordW]; mq_d = prod[WordW-1:0];
          end
          OpDiv: begin
            if (opnd_q == '0) begin
              halt_d = 1'b1; err_d = 1'b1;
            end else begin
              nega_d = ac_q[WordW-1]; negb_d = opnd_q[WordW-1];
              quo_d = ac_q[WordW-1] ? -ac_q : ac_q;
              dvs_d = opnd_q[WordW-1] ? -opnd_q : opnd_q;
              rem_d = '0; cnt_d = '0;
            end
          end
          OpJmp:   pc_d = xaddr;
          OpJz:    if (ac_q == '0) pc_d = xaddr;
          OpJnz:   if (ac_q != '0) pc_d = xaddr;
          OpJge:   if (!ac_q[WordW-1]) pc_d = xaddr;
          OpIn: begin
            ac_d = io_q; ro_in_d = 1'b1;
          end
          OpOut: begin
            ro_out_d = 1'b1; ro_val_d = ac_q;
          end
          default: ;
        endcase
      end
      StDiv: begin
        if (!trial[WordW]) begin
          rem_d = trial[WordW-1:0];
          quo_d = {quo_q[WordW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[WordW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
      end
      StDivFix: begin
        mq_d = (nega_q ^ negb_q) ? -quo_q : quo_q;
        ac_d = nega_q ? -rem_q : rem_q;
      end
      StWrite: ;
      StOut: ovalid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; clr_q <= '0; pc_q <= '0; ac_q <= '0; mq_q <= '0;
      halt_q <= 1'b0; err_q <= 1'b0; ovalid_q <= 1'b0; cnt_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; pc_q <= pc_d; ac_q <= ac_d; mq_q <= mq_d;
      halt_q <= halt_d; err_q <= err_d; ovalid_q <= ovalid_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q <= ir_d; opnd_q <= opnd_d; ir_ok_q <= ir_ok_d; x_ok_q <= x_ok_d;
    io_q <= io_d;
    ro_op_q <= ro_op_d; ro_in_q <= ro_in_d; ro_out_q <= ro_out_d; ro_val_q <= ro_val_d;
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d; nega_q <= nega_d; negb_q <= negb_d;
  end

  assign out_valid_o      = ovalid_q;
  assign opcode_done_o    = ro_op_q;
  assign next_pc_o        = pc_q;
  assign acc_value_o      = ac_q;
  assign mq_value_o       = mq_q;
  assign halted_o         = halt_q;
  assign div_error_o      = err_q;
  assign in_taken_o       = ro_in_q;
  assign out_valid_flag_o = ro_out_q;
  assign out_value_o      = ro_val_q;

  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> halt_q) else $error("error without halt");
  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> !in_ready_o) else $error("request taken while result pending");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (cnt_q < CntW'(WordW))) else $error("divider overran");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt cleared without reset");

endmodule

@@ tb/acpu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_checker
// watches both channels of the accumulator processor, keeps its own copy of
// memory and registers, predicts the result of every accepted request and
// compares each delivered result with the oldest prediction
// ----------------------------------------------------------------------------
module acpu_checker
  import acpu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    func_i,
  input  logic [AddrW-1:0]        load_address_i,
  input  logic [WordW-1:0]        load_data_i,
  input  logic [WordW-1:0]        io_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [OpW-1:0]          opcode_done_i,
  input  logic [AddrW-1:0]        next_pc_i,
  input  logic [WordW-1:0]        acc_value_i,
  input  logic [WordW-1:0]        mq_value_i,
  input  logic                    halted_i,
  input  logic                    div_error_i,
  input  logic                    in_taken_i,
  input  logic                    out_valid_flag_i,
  input  logic [WordW-1:0]        out_value_i,
  output int                      errors_o,
  output int                      pending_o,
  output logic [AddrW-1:0]        last_pc_o
);

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] pc;
    logic [WordW-1:0] acc;
    logic [WordW-1:0] mq;
    logic             halted;
    logic             div_err;
    logic             in_taken;
    logic             out_flag;
    logic [WordW-1:0] out_value;
  } cpu_result_t;

  logic [WordW-1:0] mem_q [MemWordsDefault];
  logic [AddrW-1:0] pc_q;
  logic [WordW-1:0] acc_q;
  logic [WordW-1:0] mq_q;
  logic             halt_q;
  logic             err_q;
  cpu_result_t      expected_q [$];

  function automatic cpu_result_t run_request(logic func, logic [AddrW-1:0] addr,
                                              logic [WordW-1:0] data,
                                              logic [WordW-1:0] io);
    cpu_result_t r;
    logic [WordW-1:0] word;
    logic [WordW-1:0] opnd;
    logic [AddrW-1:0] x;
    logic signed [31:0] prod;
    int a;
    int b;
    op_e op;
    r = '0;
    if (!func) begin
      mem_q[addr] = data;
    end else if (!halt_q) begin
      word = mem_q[pc_q];
      x = word[AddrW-1:0];
      opnd = mem_q[x];
      op = op_e'(word[WordW-1:AddrW]);
      r.op = op;
      pc_q = pc_q + 1'b1;
      case (op)
        OpHalt: halt_q = 1'b1;
        OpLdM: acc_q = opnd;
        OpLdMq: acc_q = mq_q;
        OpLdMqM: mq_q = opnd;
        OpSt: mem_q[x] = acc_q;
        OpStAdr: mem_q[x] = {opnd[WordW-1:AddrW], acc_q[AddrW-1:0]};
        OpAdd: acc_q = acc_q + opnd;
        OpSub: acc_q = acc_q - opnd;
        OpMul: begin
          prod = $signed(mq_q) * $signed(opnd);
          acc_q = prod[31:16];
          mq_q = prod[15:0];
        end
        OpDiv: begin
          a = $signed(acc_q);
          b = $signed(opnd);
          if (b == 0) begin
            halt_q = 1'b1;
            err_q = 1'b1;
          end else begin
            mq_q = 16'(a / b);
            acc_q = 16'(a % b);
          end
        end
        OpJmp: pc_q = x;
        OpJz: if (acc_q == '0) pc_q = x;
        OpJnz: if (acc_q != '0) pc_q = x;
        OpJge: if (!acc_q[WordW-1]) pc_q = x;
        OpIn: begin
          acc_q = io;
          r.in_taken = 1'b1;
        end
        default: begin
          r.out_flag = 1'b1;
          r.out_value = acc_q;
        end
      endcase
    end
    r.pc = pc_q;
    r.acc = acc_q;
    r.mq = mq_q;
    r.halted = halt_q;
    r.div_err = err_q;
    return r;
  endfunction

  task automatic report(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
    $display("%0t acpu_checker: %s got %h expected %h", $time, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cpu_result_t e;
    if (!rst_ni) begin
      foreach (mem_q[i]) mem_q[i] = '0;
      pc_q = '0;
      acc_q = '0;
      mq_q = '0;
      halt_q = 1'b0;
      err_q = 1'b0;
      expected_q.delete();
      errors_o = 0;
      pending_o <= 0;
      last_pc_o <= '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result, pc", next_pc_i, 'x);
        end else begin
          e = expected_q.pop_front();
          if (opcode_done_i !== e.op) report("opcode_done", opcode_done_i, e.op);
          if (next_pc_i !== e.pc) report("next_pc", next_pc_i, e.pc);
          if (acc_value_i !== e.acc) report("acc_value", acc_value_i, e.acc);
          if (mq_value_i !== e.mq) report("mq_value", mq_value_i, e.mq);
          if (halted_i !== e.halted) report("halted", halted_i, e.halted);
          if (div_error_i !== e.div_err) report("div_error", div_error_i, e.div_err);
          if (in_taken_i !== e.in_taken) report("in_taken", in_taken_i, e.in_taken);
          if (out_valid_flag_i !== e.out_flag) begin
            report("out_valid", out_valid_flag_i, e.out_flag);
          end
          if (out_value_i !== e.out_value) report("out_value", out_value_i, e.out_value);
        end
        last_pc_o <= next_pc_i;
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(run_request(func_i, load_address_i, load_data_i, io_in_i));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives program loads and instruction steps into the accumulator processor:
// directed corner cases, then random instruction streams, then a final halt;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
  import acpu_pkg::*;

  localparam int NumItems = 1800;
  localparam int WatchLimit = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic func;
  logic [AddrW-1:0] load_address;
  logic [WordW-1:0] load_data;
  logic signed [WordW-1:0] io_in;
  logic out_valid;
  logic out_ready;
  logic [OpW-1:0] opcode_done;
  logic [AddrW-1:0] next_pc;
  logic signed [WordW-1:0] acc_value;
  logic signed [WordW-1:0] mq_value;
  logic halted;
  logic div_error;
  logic in_taken;
  logic out_flag;
  logic signed [WordW-1:0] out_value;

  int errors;
  int pending;
  logic [AddrW-1:0] last_pc;
  logic [AddrW-1:0] cur_pc;
  logic pc_lost;
  logic calm;
  logic hold;
  logic hold_go;
  int n_sent;
  int idle_cycles;

  accumulator_cpu_16bit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func),
    .load_address_i  (load_address),
    .load_data_i     (load_data),
    .io_in_i         (io_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .opcode_done_o   (opcode_done),
    .next_pc_o       (next_pc),
    .acc_value_o     (acc_value),
    .mq_value_o      (mq_value),
    .halted_o        (halted),
    .div_error_o     (div_error),
    .in_taken_o      (in_taken),
    .out_valid_flag_o(out_flag),
    .out_value_o     (out_value)
  );

  acpu_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .func_i          (func),
    .load_address_i  (load_address),
    .load_data_i     (load_data),
    .io_in_i         (io_in),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .opcode_done_i   (opcode_done),
    .next_pc_i       (next_pc),
    .acc_value_i     (acc_value),
    .mq_value_i      (mq_value),
    .halted_i        (halted),
    .div_error_i     (div_error),
    .in_taken_i      (in_taken),
    .out_valid_flag_i(out_flag),
    .out_value_i     (out_value),
    .errors_o        (errors),
    .pending_o       (pending),
    .last_pc_o       (last_pc)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n || hold) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 12);
    end
  end

  // long receiver stall while requests keep coming
  initial begin
    hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold <= 1'b1;
    repeat (300) @(posedge clk);
    hold <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic f, logic [AddrW-1:0] a, logic [WordW-1:0] d,
                      logic [WordW-1:0] io);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    load_address <= a;
    load_data <= d;
    io_in <= io;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    calm <= (n_sent >= 900 && n_sent < 1200);
    if (n_sent == 600) hold_go = 1'b1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load(logic [AddrW-1:0] a, logic [WordW-1:0] d);
    send(1'b0, a, d, 16'($urandom));
  endtask

  // writes the instruction at pc, then steps it
  task automatic exec(op_e op, logic [AddrW-1:0] x, logic [WordW-1:0] io);
    logic [AddrW-1:0] nxt;
    if (pc_lost) begin
      drain();
      cur_pc = last_pc;
      pc_lost = 1'b0;
    end
    load(cur_pc, {op, x});
    send(1'b1, AddrW'($urandom), 16'($urandom), io);
    nxt = cur_pc + 1'b1;
    if (op == OpJmp) begin
      nxt = x;
    end else if ((op == OpJz || op == OpJnz || op == OpJge) && x != nxt) begin
      pc_lost = 1'b1;
    end
    cur_pc = nxt;
  endtask

  initial begin
    op_e op;
    logic [AddrW-1:0] x;
    rst_n = 1'b0;
    in_valid = 1'b0;
    func = 1'b0;
    load_address = '0;
    load_data = '0;
    io_in = '0;
    calm = 1'b0;
    hold_go = 1'b0;
    idle_cycles = 0;
    n_sent = 0;
    cur_pc = '0;
    pc_lost = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // corner values
    load(12'd100, 16'h8000);
    load(12'd101, 16'hFFFF);
    load(12'd102, 16'h7FFF);
    exec(OpLdM, 12'd100, 16'h0000);
    exec(OpDiv, 12'd101, 16'hFFFF);
    exec(OpLdM, 12'd102, 16'h0000);
    exec(OpAdd, 12'd102, 16'h0000);
    exec(OpSub, 12'd100, 16'h0000);
    exec(OpLdMqM, 12'd100, 16'h0000);
    exec(OpMul, 12'd100, 16'h0000);
    exec(OpIn, 12'd0, 16'h8000);
    exec(OpOut, 12'd0, 16'h7FFF);
    exec(OpLdMq, 12'd0, 16'h0000);
    exec(OpSt, 12'd103, 16'h0000);
    exec(OpStAdr, 12'd103, 16'h0000);
    exec(OpJmp, 12'hFFF, 16'h0000);
    exec(OpIn, 12'hFFF, 16'h7FFF);

    while (n_sent < NumItems) begin
      if ($urandom_range(99) < 20) begin
        load(AddrW'($urandom), 16'($urandom));
      end else begin
        op = op_e'($urandom_range(15, 1));
        x = AddrW'($urandom);
        if (op == OpDiv) begin
          load(x, 16'($urandom_range(16'hFFFF, 1)));
        end else if ((op == OpJz || op == OpJnz || op == OpJge)
                     && $urandom_range(1)) begin
          x = cur_pc + 1'b1;
        end
        exec(op, x, 16'($urandom));
      end
    end

    // stop the machine, then poke it while halted
    drain();
    cur_pc = last_pc;
    pc_lost = 1'b0;
    if ($urandom_range(1)) begin
      exec(OpHalt, AddrW'($urandom), 16'($urandom));
    end else begin
      x = cur_pc + 12'd7;
      load(x, 16'h0000);
      exec(OpDiv, x, 16'($urandom));
    end
    repeat (3) send(1'b1, AddrW'($urandom), 16'($urandom), 16'($urandom));
    load(AddrW'($urandom), 16'($urandom));
    send(1'b1, AddrW'($urandom), 16'($urandom), 16'($urandom));

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ accumulator_cpu_16bit.f @@
hw/rtl/acpu_pkg.sv
hw/rtl/accumulator_cpu_16bit.sv
tb/acpu_checker.sv
tb/tb.sv
